/* rtl/fractional_n_divider_calc_assert.svh */
// assertion macros for the fractional-n divider calculation block
`ifndef FRACTIONAL_N_DIVIDER_CALC_ASSERT_SVH
`define FRACTIONAL_N_DIVIDER_CALC_ASSERT_SVH

// clocked assertion, off while reset is held
`define FNDIV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// same with an overlapping implication
`define FNDIV_ASSERT_IMP(lbl, ante, cons, msg) \
  `FNDIV_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

/* rtl/fndiv_pkg.sv */
// types and constants shared by the fractional-n divider calculation block
package fndiv_pkg;

  localparam int FREQ_W     = 20;
  localparam int PD_W       = 16;
  localparam int EXP_W      = 3;
  localparam int PRESC_W    = 2;
  localparam int NINT_W     = 16;
  localparam int FRAC_HI_W  = 16;
  localparam int FRAC_LO_W  = 8;
  localparam int FRAC_W     = FRAC_HI_W + FRAC_LO_W;
  localparam int DIV_W      = PD_W + 2;
  localparam int NUM_W      = FREQ_W + FRAC_W;
  localparam int DIV_BITS   = 4;
  localparam int DIV_STAGES = NUM_W / DIV_BITS;
  localparam int LATENCY    = DIV_STAGES + 3;

  localparam int MAX_LO_EXP = 5;
  localparam int EXT_W      = FREQ_W + MAX_LO_EXP;

  localparam logic [EXT_W-1:0]   LO_TARGET    = EXT_W'(540000);
  localparam logic [FREQ_W-1:0]  PRESC_THRESH = FREQ_W'(320000);
  localparam logic [PD_W-1:0]    PD_RESET     = PD_W'(2000);
  localparam logic [PRESC_W-1:0] PRESC_DIV2   = PRESC_W'(1);
  localparam logic [PRESC_W-1:0] PRESC_DIV4   = PRESC_W'(2);

  typedef struct packed {
    logic [EXP_W-1:0]   lo_div_exp;
    logic [PRESC_W-1:0] presc_code;
    logic [FREQ_W-1:0]  vco;
    logic               zero;
    logic               sat;
    logic [DIV_W-1:0]   div;
    logic [DIV_W-1:0]   rem;
    logic [NUM_W-1:0]   nq;
  } fndiv_beat_t;

endpackage

/* rtl/fndiv_front.sv */
// exponent, prescaler and divisor selection, overflow check and divider setup
module fndiv_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [fndiv_pkg::FREQ_W-1:0] out_freq_i,
  input  logic [fndiv_pkg::PD_W-1:0]   pd_freq_i,
  output logic                       valid_o,
  output fndiv_pkg::fndiv_beat_t     beat_o
);
  import fndiv_pkg::*;

  logic             a_valid_d, a_valid_q;
  fndiv_beat_t      a_d, a_q;
  logic             b_valid_q;
  fndiv_beat_t      b_d, b_q;
  logic [EXT_W-1:0] f_ext;

  assign f_ext = EXT_W'(out_freq_i);

  // stage a: exponent, vco, prescaler, divisor
  always_comb begin
    a_d = '0;
    for (int k = 1; k <= MAX_LO_EXP; k++) begin
      if ((f_ext << k) <= LO_TARGET) begin
        a_d.lo_div_exp = EXP_W'(k);
      end
    end
    a_d.zero = (out_freq_i == '0);
    if (a_d.zero) begin
      a_d.lo_div_exp = '0;
    end
    a_d.vco = FREQ_W'(f_ext << a_d.lo_div_exp);
    if (a_d.vco > PRESC_THRESH) begin
      a_d.presc_code = PRESC_DIV4;
      a_d.div        = {pd_freq_i, 2'b00};
    end else begin
      a_d.presc_code = PRESC_DIV2;
      a_d.div        = {1'b0, pd_freq_i, 1'b0};
    end
  end

  assign a_valid_d = start_i;

  // stage b: overflow check, divider init
  always_comb begin
    b_d     = a_q;
    b_d.sat = !a_q.zero &&
              ((a_q.div == '0) || (DIV_W'(a_q.vco >> NINT_W) >= a_q.div));
    b_d.rem = '0;
    b_d.nq  = {a_q.vco, {FRAC_W{1'b0}}};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      a_valid_q <= a_valid_d;
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
  end

  assign valid_o = b_valid_q;
  assign beat_o  = b_q;

endmodule

/* rtl/fndiv_div_stage.sv */
// one registered stage of the restoring divider, several quotient bits
module fndiv_div_stage (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  fndiv_pkg::fndiv_beat_t beat_i,
  output logic                   valid_o,
  output fndiv_pkg::fndiv_beat_t beat_o
);
  import fndiv_pkg::*;

  fndiv_beat_t      s;
  logic [DIV_W:0]   t;
  fndiv_beat_t      beat_q;
  logic             valid_q;

  always_comb begin
    s = beat_i;
    t = '0;
    for (int i = 0; i < DIV_BITS; i++) begin
      t    = {s.rem, s.nq[NUM_W-1]};
      s.nq = {s.nq[NUM_W-2:0], 1'b0};
      if (t >= {1'b0, s.div}) begin
        s.rem   = DIV_W'(t - {1'b0, s.div});
        s.nq[0] = 1'b1;
      end else begin
        s.rem = t[DIV_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    beat_q <= s;
  end

  assign valid_o = valid_q;
  assign beat_o  = beat_q;

endmodule

/* rtl/fractional_n_divider_calc.sv */
// top level of the fractional-n pll divider calculation pipeline
//
// channel   direction  handshake             payload
// request   in         start_i, busy_o       out_freq_i
// result    out        done_o (strobe)       lo_div_exp_o .. calc_error_o
// config    in         pd_freq_we_i          pd_freq_i
//
// one request per cycle; each start beat passes through, in order,
// two setup stages, eleven 4-bit divider stages and one output register
// reset clears the valid bits and loads pd_freq with 2000
// busy_o stays low: the pipeline never stalls and results are not held
module fractional_n_divider_calc (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic [fndiv_pkg::FREQ_W-1:0]    out_freq_i,
  input  logic                            pd_freq_we_i,
  input  logic [fndiv_pkg::PD_W-1:0]      pd_freq_i,
  output logic                            done_o,
  output logic [fndiv_pkg::EXP_W-1:0]     lo_div_exp_o,
  output logic [fndiv_pkg::PRESC_W-1:0]   presc_code_o,
  output logic [fndiv_pkg::FREQ_W-1:0]    vco_freq_o,
  output logic [fndiv_pkg::NINT_W-1:0]    n_int_o,
  output logic [fndiv_pkg::FRAC_HI_W-1:0] n_frac_hi_o,
  output logic [fndiv_pkg::FRAC_LO_W-1:0] n_frac_lo_o,
  output logic                            calc_error_o
);
  import fndiv_pkg::*;

  logic [PD_W-1:0]      pd_freq_q;
  logic                 stg_valid [0:DIV_STAGES];
  fndiv_beat_t          stg_beat  [0:DIV_STAGES];
  fndiv_beat_t          res;

  logic                 done_d, done_q;
  logic [EXP_W-1:0]     exp_d, exp_q;
  logic [PRESC_W-1:0]   presc_d, presc_q;
  logic [FREQ_W-1:0]    vco_d, vco_q;
  logic [NINT_W-1:0]    nint_d, nint_q;
  logic [FRAC_HI_W-1:0] fhi_d, fhi_q;
  logic [FRAC_LO_W-1:0] flo_d, flo_q;
  logic                 err_d, err_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pd_freq_q <= PD_RESET;
    end else if (pd_freq_we_i) begin
      pd_freq_q <= pd_freq_i;
    end
  end

  assign busy_o = 1'b0;

  fndiv_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .out_freq_i (out_freq_i),
    .pd_freq_i  (pd_freq_q),
    .valid_o    (stg_valid[0]),
    .beat_o     (stg_beat[0])
  );

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    fndiv_div_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (stg_valid[g]),
      .beat_i  (stg_beat[g]),
      .valid_o (stg_valid[g+1]),
      .beat_o  (stg_beat[g+1])
    );
  end

  assign res = stg_beat[DIV_STAGES];

  always_comb begin
    done_d  = stg_valid[DIV_STAGES];
    exp_d   = res.lo_div_exp;
    presc_d = res.presc_code;
    vco_d   = res.vco;
    err_d   = res.zero | res.sat;
    if (res.sat) begin
      nint_d = '1;
      fhi_d  = '1;
      flo_d  = '1;
    end else if (res.zero) begin
      nint_d = '0;
      fhi_d  = '0;
      flo_d  = '0;
    end else begin
      nint_d = res.nq[FRAC_W+NINT_W-1:FRAC_W];
      fhi_d  = res.nq[FRAC_W-1:FRAC_LO_W];
      flo_d  = res.nq[FRAC_LO_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    exp_q   <= exp_d;
    presc_q <= presc_d;
    vco_q   <= vco_d;
    nint_q  <= nint_d;
    fhi_q   <= fhi_d;
    flo_q   <= flo_d;
    err_q   <= err_d;
  end

  assign done_o       = done_q;
  assign lo_div_exp_o = exp_q;
  assign presc_code_o = presc_q;
  assign vco_freq_o   = vco_q;
  assign n_int_o      = nint_q;
  assign n_frac_hi_o  = fhi_q;
  assign n_frac_lo_o  = flo_q;
  assign calc_error_o = err_q;

endmodule

/* rtl/fndiv_chk.sv */
// port checker for the fractional-n divider calculation block and its bind
module fndiv_chk (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            start_i,
  input logic                            busy_o,
  input logic [fndiv_pkg::FREQ_W-1:0]    out_freq_i,
  input logic                            pd_freq_we_i,
  input logic [fndiv_pkg::PD_W-1:0]      pd_freq_i,
  input logic                            done_o,
  input logic [fndiv_pkg::EXP_W-1:0]     lo_div_exp_o,
  input logic [fndiv_pkg::PRESC_W-1:0]   presc_code_o,
  input logic [fndiv_pkg::FREQ_W-1:0]    vco_freq_o,
  input logic [fndiv_pkg::NINT_W-1:0]    n_int_o,
  input logic [fndiv_pkg::FRAC_HI_W-1:0] n_frac_hi_o,
  input logic [fndiv_pkg::FRAC_LO_W-1:0] n_frac_lo_o,
  input logic                            calc_error_o
);
  import fndiv_pkg::*;
  `include "fractional_n_divider_calc_assert.svh"

  `FNDIV_ASSERT_IMP(a_done_has_start, done_o, $past(start_i && !busy_o, LATENCY), "result beat without a start beat")
  `FNDIV_ASSERT_IMP(a_exp_range, done_o, lo_div_exp_o <= EXP_W'(MAX_LO_EXP), "exponent out of range")
  `FNDIV_ASSERT_IMP(a_presc_match, done_o, (presc_code_o == PRESC_DIV4) == (vco_freq_o > PRESC_THRESH), "prescaler does not match vco")
  `FNDIV_ASSERT_IMP(a_zero_result, done_o && vco_freq_o == '0, calc_error_o && n_int_o == '0 && n_frac_hi_o == '0 && n_frac_lo_o == '0, "zero frequency result wrong")
  `FNDIV_ASSERT_IMP(a_sat_result, done_o && calc_error_o && vco_freq_o != '0, n_int_o == '1 && n_frac_hi_o == '1 && n_frac_lo_o == '1, "error result not saturated")

endmodule

bind fractional_n_divider_calc fndiv_chk u_fndiv_chk (.*);
